[rtl/rdf_pkg.sv]
`timescale 1ns / 1ps

package rdf_pkg;

    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_ACCUM = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_SAMP  = 2'd1;
    localparam logic [1:0] ST_FEW_ATOM = 2'd2;
    localparam logic [1:0] ST_BAD_BIN  = 2'd3;

    localparam logic [2:0] REG_CUTOFF = 3'd0;
    localparam logic [2:0] REG_BIN_W  = 3'd1;
    localparam logic [2:0] REG_BOX_X  = 3'd2;
    localparam logic [2:0] REG_BOX_Y  = 3'd3;
    localparam logic [2:0] REG_BOX_Z  = 3'd4;
    localparam logic [2:0] REG_VOLUME = 3'd5;

    localparam logic [2:0] BN_LOAD_NUM = 3'd0;
    localparam logic [2:0] BN_LOAD_DEN = 3'd1;
    localparam logic [2:0] BN_MUL_NUM  = 3'd2;
    localparam logic [2:0] BN_MUL_DEN  = 3'd3;
    localparam logic [2:0] BN_DIV      = 3'd4;

    localparam int          BN_W     = 256;
    localparam int          BN_LIMBS = BN_W / 32;
    localparam logic [31:0] PI_Q29   = 32'd1686629713;
    localparam int          MIN_BINS = 10;

    typedef struct packed {
        logic        start;
        logic [2:0]  op;
        logic [47:0] operand;
    } bn_req_t;

endpackage

[rtl/rdf_ram.sv]
`timescale 1ns / 1ps

module rdf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/rdf_div.sv]
`timescale 1ns / 1ps

module rdf_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient,
    output logic [31:0] remainder
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] quo_reg;
    logic [32:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [32:0] trial;
    logic        fits;

    assign trial = {rem_reg[31:0], quo_reg[31]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? trial - {1'b0, dsr_reg} : trial;
            quo_reg <= {quo_reg[30:0], fits};
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg[31:0];

endmodule

[rtl/rdf_isqrt.sv]
`timescale 1ns / 1ps

module rdf_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [63:0] rad_reg;
    logic [33:0] rem_reg;
    logic [31:0] root_reg;
    logic [35:0] rem_sh;
    logic [35:0] trial;
    logic        fits;

    assign rem_sh = {rem_reg, rad_reg[63:62]};
    assign trial  = {2'b00, root_reg, 2'b01};
    assign fits   = rem_sh >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[61:0], 2'b00};
            rem_reg  <= fits ? 34'(rem_sh - trial) : 34'(rem_sh);
            root_reg <= {root_reg[30:0], fits};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

[rtl/rdf_bignum.sv]
`timescale 1ns / 1ps

module rdf_bignum import rdf_pkg::*; #(
    parameter int SHIFT = 76
) (
    input  logic        clk,
    input  logic        rst_n,
    input  bn_req_t     req,
    output logic        done,
    output logic [31:0] quotient
);

    localparam logic [2:0] M_IDLE = 3'd0;
    localparam logic [2:0] M_MULN = 3'd1;
    localparam logic [2:0] M_MULD = 3'd2;
    localparam logic [2:0] M_DCHK = 3'd3;
    localparam logic [2:0] M_DIV  = 3'd4;

    logic [2:0]      mode_reg;
    logic            done_reg;
    logic [5:0]      cnt_reg;
    logic [BN_W-1:0] num_reg;
    logic [BN_W-1:0] den_reg;
    logic [BN_W-1:0] dsr_reg;
    logic [31:0]     word_reg;
    logic [31:0]     carry_reg;
    logic [31:0]     quo_reg;
    logic [BN_W-1:0] src;
    logic [63:0]     prod;
    logic [BN_W-1:0] shifted;
    logic [BN_W-1:0] half;
    logic            fits;

    assign src     = (mode_reg == M_MULN) ? num_reg : den_reg;
    assign prod    = 64'(src[31:0]) * 64'(word_reg) + 64'(carry_reg);
    assign shifted = {prod[31:0], src[BN_W-1:32]};
    assign half    = dsr_reg >> 1;
    assign fits    = num_reg >= half;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_IDLE;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (mode_reg)
                M_IDLE:
                begin
                    cnt_reg <= '0;
                    if (req.start)
                    begin
                        unique case (req.op)
                            BN_MUL_NUM: mode_reg <= M_MULN;
                            BN_MUL_DEN: mode_reg <= M_MULD;
                            BN_DIV:     mode_reg <= M_DCHK;
                            default:    done_reg <= 1'b1;
                        endcase
                    end
                end
                M_MULN, M_MULD:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'(BN_LIMBS - 1))
                    begin
                        mode_reg <= M_IDLE;
                        done_reg <= 1'b1;
                    end
                end
                M_DCHK:
                begin
                    if (num_reg >= dsr_reg)
                    begin
                        mode_reg <= M_IDLE;
                        done_reg <= 1'b1;
                    end
                    else
                    begin
                        mode_reg <= M_DIV;
                    end
                end
                M_DIV:
                begin
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == 6'd31)
                    begin
                        mode_reg <= M_IDLE;
                        done_reg <= 1'b1;
                    end
                end
                default:
                begin
                    mode_reg <= M_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (mode_reg)
            M_IDLE:
            begin
                carry_reg <= '0;
                word_reg  <= req.operand[31:0];
                if (req.start && req.op == BN_LOAD_NUM)
                begin
                    num_reg <= BN_W'(req.operand) << SHIFT;
                end
                if (req.start && req.op == BN_LOAD_DEN)
                begin
                    den_reg <= BN_W'(req.operand);
                end
                if (req.start && req.op == BN_DIV)
                begin
                    dsr_reg <= den_reg << 32;
                end
            end
            M_MULN:
            begin
                num_reg   <= shifted;
                carry_reg <= prod[63:32];
            end
            M_MULD:
            begin
                den_reg   <= shifted;
                carry_reg <= prod[63:32];
            end
            M_DCHK:
            begin
                quo_reg <= '1;
            end
            M_DIV:
            begin
                if (fits)
                begin
                    num_reg <= num_reg - half;
                end
                dsr_reg <= half;
                quo_reg <= {quo_reg[30:0], fits};
            end
            default:
            begin
                carry_reg <= '0;
            end
        endcase
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/pair_distance_histogram_rdf.sv]
`timescale 1ns / 1ps

// Radial distribution function histogram. A command is taken when start is high and busy is
// low, and each command gives one result, shown for a single cycle while done is high; the
// receiver cannot hold it off, so it must take every transfer as it comes. A load gives its
// result in the cycle after it is taken. A clear, and the pass that follows reset, sweeps the
// histogram memory one bin per cycle with busy high. An accumulate walks all N(N-1)/2 pairs
// one after another, unless the bin count is zero, using the shared divider that serves the
// bin count, the three periodic wraps and the bin index, and using the square root. A read
// finds the bin count, then, for a nonempty bin, runs two loads, eight limb multiplies and a
// long division for g(r).
module pair_distance_histogram_rdf import rdf_pkg::*; #(
    parameter int MAX_ATOMS = 1024,
    parameter int MAX_BINS  = 1024,
    parameter int FRAC_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  command,
    input  logic [9:0]  atom_index,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [10:0] atom_count,
    input  logic [9:0]  bin_index,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    output logic        done,
    output logic [1:0]  status,
    output logic [31:0] bin_center,
    output logic [31:0] bin_count,
    output logic [31:0] g_value,
    output logic [31:0] sample_total
);

    localparam int AW  = $clog2(MAX_ATOMS);
    localparam int CW  = $clog2(MAX_ATOMS + 1);
    localparam int HW  = $clog2(MAX_BINS);
    localparam int NBW = $clog2(MAX_BINS + 1);
    localparam int SH  = 3 * FRAC_BITS + 28;

    localparam logic [4:0] S_CLR       = 5'd0;
    localparam logic [4:0] S_IDLE      = 5'd1;
    localparam logic [4:0] S_NB_GO     = 5'd2;
    localparam logic [4:0] S_NB_WAIT   = 5'd3;
    localparam logic [4:0] S_DISPATCH  = 5'd4;
    localparam logic [4:0] S_RD_I      = 5'd5;
    localparam logic [4:0] S_LAT_I     = 5'd6;
    localparam logic [4:0] S_RD_J      = 5'd7;
    localparam logic [4:0] S_LAT_J     = 5'd8;
    localparam logic [4:0] S_AX_PREP   = 5'd9;
    localparam logic [4:0] S_AX_GO     = 5'd10;
    localparam logic [4:0] S_AX_WAIT   = 5'd11;
    localparam logic [4:0] S_SQ        = 5'd12;
    localparam logic [4:0] S_ADD       = 5'd13;
    localparam logic [4:0] S_SQRT_GO   = 5'd14;
    localparam logic [4:0] S_SQRT_WAIT = 5'd15;
    localparam logic [4:0] S_BIN_GO    = 5'd16;
    localparam logic [4:0] S_BIN_WAIT  = 5'd17;
    localparam logic [4:0] S_HRD       = 5'd18;
    localparam logic [4:0] S_HWR       = 5'd19;
    localparam logic [4:0] S_NEXT      = 5'd20;
    localparam logic [4:0] S_ACC_END   = 5'd21;
    localparam logic [4:0] S_RD_H      = 5'd22;
    localparam logic [4:0] S_RD_D      = 5'd23;
    localparam logic [4:0] S_G_GO      = 5'd24;
    localparam logic [4:0] S_G_WAIT    = 5'd25;

    localparam logic [3:0] G_VOL   = 4'd0;
    localparam logic [3:0] G_CNT   = 4'd1;
    localparam logic [3:0] G_THREE = 4'd2;
    localparam logic [3:0] G_PI    = 4'd3;
    localparam logic [3:0] G_SNAP  = 4'd4;
    localparam logic [3:0] G_PAIRS = 4'd5;
    localparam logic [3:0] G_DR1   = 4'd6;
    localparam logic [3:0] G_DR2   = 4'd7;
    localparam logic [3:0] G_DR3   = 4'd8;
    localparam logic [3:0] G_SHELL = 4'd9;
    localparam logic [3:0] G_DIV   = 4'd10;

    logic [4:0]     state_reg;
    logic [31:0]    cutoff_reg;
    logic [31:0]    bw_reg;
    logic [31:0]    boxx_reg;
    logic [31:0]    boxy_reg;
    logic [31:0]    boxz_reg;
    logic [47:0]    vol_reg;
    logic [31:0]    snap_reg;
    logic [1:0]     cmd_reg;
    logic [CW-1:0]  n_reg;
    logic [CW-1:0]  i_reg;
    logic [CW-1:0]  j_reg;
    logic [10:0]    nread_reg;
    logic [9:0]     b_reg;
    logic [NBW-1:0] nb_reg;
    logic [HW-1:0]  hist_addr_reg;
    logic           clr_cmd_reg;
    logic [31:0]    ci_reg [3];
    logic [31:0]    cj_reg [3];
    logic [1:0]     axis_reg;
    logic [31:0]    m_reg;
    logic [31:0]    len_reg;
    logic [31:0]    mw_reg;
    logic [63:0]    prod_reg;
    logic [63:0]    sum_reg;
    logic [31:0]    r_reg;
    logic [31:0]    cnt_reg;
    logic [21:0]    nn1_reg;
    logic [22:0]    k_reg;
    logic [3:0]     g_step_reg;
    logic           done_reg;
    logic [1:0]     status_reg;
    logic [31:0]    center_reg;
    logic [31:0]    count_out_reg;
    logic [31:0]    g_reg;

    logic           load_we;
    logic [AW-1:0]  coord_raddr;
    logic [31:0]    rx_data;
    logic [31:0]    ry_data;
    logic [31:0]    rz_data;
    logic           hist_we;
    logic [31:0]    hist_wdata;
    logic [31:0]    hist_rdata;
    logic           div_start;
    logic [31:0]    div_a;
    logic [31:0]    div_b;
    logic           div_done;
    logic [31:0]    div_quot;
    logic [31:0]    div_rem;
    logic           sqrt_done;
    logic [31:0]    sqrt_root;
    bn_req_t        bn_req;
    logic           bn_done;
    logic [31:0]    bn_quot;
    logic           accept;
    logic [CW-1:0]  n_clamp;
    logic [NBW-1:0] nb_clamp;
    logic [32:0]    diff;
    logic [31:0]    mag;
    logic [31:0]    axis_len;
    logic [64:0]    sum_wide;
    logic [31:0]    snap_inc;
    logic [43:0]    ctr_full;
    logic [31:0]    ctr_sat;
    logic [20:0]    b_prod;

    assign accept   = start && state_reg == S_IDLE;
    assign busy     = state_reg != S_IDLE;
    assign load_we  = accept && command == CMD_LOAD && 32'(atom_index) < MAX_ATOMS;
    assign n_clamp  = (32'(atom_count) > MAX_ATOMS) ? CW'(MAX_ATOMS) : CW'(atom_count);
    assign nb_clamp = (div_quot > 32'(MAX_BINS)) ? NBW'(MAX_BINS) : NBW'(div_quot);
    assign diff     = {cj_reg[axis_reg][31], cj_reg[axis_reg]}
                    - {ci_reg[axis_reg][31], ci_reg[axis_reg]};
    assign mag      = diff[32] ? 32'(-diff) : diff[31:0];
    assign sum_wide = {1'b0, sum_reg} + {1'b0, prod_reg};
    assign snap_inc = (snap_reg == '1) ? snap_reg : snap_reg + 32'd1;
    assign ctr_full = 44'({b_reg, 1'b1}) * 44'(bw_reg) + 44'd1;
    assign ctr_sat  = (|ctr_full[43:33]) ? '1 : ctr_full[32:1];
    assign b_prod   = 21'(b_reg) * (21'(b_reg) + 21'd1);

    always_comb
    begin
        unique case (axis_reg)
            2'd0:    axis_len = boxx_reg;
            2'd1:    axis_len = boxy_reg;
            default: axis_len = boxz_reg;
        endcase
    end

    always_comb
    begin
        coord_raddr = (state_reg == S_RD_I) ? i_reg[AW-1:0] : j_reg[AW-1:0];
        hist_we     = state_reg == S_CLR || (state_reg == S_HWR && hist_rdata != '1);
        hist_wdata  = (state_reg == S_CLR) ? 32'd0 : hist_rdata + 32'd1;
        div_start   = state_reg == S_NB_GO || state_reg == S_AX_GO || state_reg == S_BIN_GO;
        unique case (state_reg)
            S_NB_GO:
            begin
                div_a = cutoff_reg;
                div_b = bw_reg;
            end
            S_AX_GO:
            begin
                div_a = m_reg;
                div_b = len_reg;
            end
            default:
            begin
                div_a = r_reg;
                div_b = bw_reg;
            end
        endcase
    end

    always_comb
    begin
        bn_req.start   = state_reg == S_G_GO;
        bn_req.op      = BN_MUL_DEN;
        bn_req.operand = 48'(bw_reg);
        unique case (g_step_reg)
            G_VOL:
            begin
                bn_req.op      = BN_LOAD_NUM;
                bn_req.operand = vol_reg;
            end
            G_CNT:
            begin
                bn_req.op      = BN_MUL_NUM;
                bn_req.operand = 48'(cnt_reg);
            end
            G_THREE:
            begin
                bn_req.op      = BN_MUL_NUM;
                bn_req.operand = 48'd3;
            end
            G_PI:
            begin
                bn_req.op      = BN_LOAD_DEN;
                bn_req.operand = 48'(PI_Q29);
            end
            G_SNAP:  bn_req.operand = 48'(snap_reg);
            G_PAIRS: bn_req.operand = 48'(nn1_reg);
            G_DR1, G_DR2, G_DR3: bn_req.operand = 48'(bw_reg);
            G_SHELL: bn_req.operand = 48'(k_reg);
            default:
            begin
                bn_req.op      = BN_DIV;
                bn_req.operand = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLR;
            cutoff_reg    <= 32'd655360;
            bw_reg        <= 32'd6554;
            boxx_reg      <= 32'd1310720;
            boxy_reg      <= 32'd1310720;
            boxz_reg      <= 32'd1310720;
            vol_reg       <= 48'd524288000;
            snap_reg      <= '0;
            cmd_reg       <= CMD_LOAD;
            n_reg         <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            nread_reg     <= '0;
            b_reg         <= '0;
            nb_reg        <= '0;
            hist_addr_reg <= '0;
            clr_cmd_reg   <= 1'b0;
            ci_reg        <= '{default: '0};
            cj_reg        <= '{default: '0};
            axis_reg      <= '0;
            m_reg         <= '0;
            len_reg       <= '0;
            mw_reg        <= '0;
            prod_reg      <= '0;
            sum_reg       <= '0;
            r_reg         <= '0;
            cnt_reg       <= '0;
            nn1_reg       <= '0;
            k_reg         <= '0;
            g_step_reg    <= G_VOL;
            done_reg      <= 1'b0;
            status_reg    <= ST_OK;
            center_reg    <= '0;
            count_out_reg <= '0;
            g_reg         <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_CUTOFF: cutoff_reg <= cfg_data[31:0];
                    REG_BIN_W:  bw_reg     <= cfg_data[31:0];
                    REG_BOX_X:  boxx_reg   <= cfg_data[31:0];
                    REG_BOX_Y:  boxy_reg   <= cfg_data[31:0];
                    REG_BOX_Z:  boxz_reg   <= cfg_data[31:0];
                    REG_VOLUME: vol_reg    <= cfg_data;
                    default:    vol_reg    <= vol_reg;
                endcase
            end

            unique case (state_reg)
                S_CLR:
                begin
                    hist_addr_reg <= hist_addr_reg + HW'(1);
                    if (32'(hist_addr_reg) == MAX_BINS - 1)
                    begin
                        hist_addr_reg <= '0;
                        state_reg     <= S_IDLE;
                        if (clr_cmd_reg)
                        begin
                            done_reg      <= 1'b1;
                            status_reg    <= ST_OK;
                            center_reg    <= '0;
                            count_out_reg <= '0;
                            g_reg         <= '0;
                        end
                    end
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        cmd_reg   <= command;
                        n_reg     <= n_clamp;
                        nread_reg <= atom_count;
                        b_reg     <= bin_index;
                        unique case (command)
                            CMD_LOAD:
                            begin
                                done_reg      <= 1'b1;
                                status_reg    <= ST_OK;
                                center_reg    <= '0;
                                count_out_reg <= '0;
                                g_reg         <= '0;
                            end
                            CMD_ACCUM, CMD_READ:
                            begin
                                if (command == CMD_ACCUM && n_clamp < CW'(2))
                                begin
                                    done_reg      <= 1'b1;
                                    status_reg    <= ST_FEW_ATOM;
                                    center_reg    <= '0;
                                    count_out_reg <= '0;
                                    g_reg         <= '0;
                                end
                                else if (bw_reg != '0)
                                begin
                                    state_reg <= S_NB_GO;
                                end
                                else
                                begin
                                    nb_reg    <= '0;
                                    state_reg <= S_DISPATCH;
                                end
                            end
                            CMD_CLEAR:
                            begin
                                snap_reg      <= '0;
                                hist_addr_reg <= '0;
                                clr_cmd_reg   <= 1'b1;
                                state_reg     <= S_CLR;
                            end
                        endcase
                    end
                end
                S_NB_GO:
                begin
                    state_reg <= S_NB_WAIT;
                end
                S_NB_WAIT:
                begin
                    if (div_done)
                    begin
                        nb_reg    <= nb_clamp;
                        state_reg <= S_DISPATCH;
                    end
                end
                S_DISPATCH:
                begin
                    center_reg    <= '0;
                    count_out_reg <= '0;
                    g_reg         <= '0;
                    nn1_reg       <= 22'(nread_reg) * 22'(nread_reg - 11'd1);
                    k_reg         <= 23'(b_prod) * 23'd3 + 23'd1;
                    if (cmd_reg == CMD_ACCUM)
                    begin
                        i_reg     <= '0;
                        j_reg     <= CW'(1);
                        state_reg <= (nb_reg == '0) ? S_ACC_END : S_RD_I;
                    end
                    else if (snap_reg == '0)
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= ST_NO_SAMP;
                        state_reg  <= S_IDLE;
                    end
                    else if (nread_reg < 11'd2)
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= ST_FEW_ATOM;
                        state_reg  <= S_IDLE;
                    end
                    else if (vol_reg == '0 || 32'(nb_reg) < MIN_BINS
                             || 32'(b_reg) >= 32'(nb_reg))
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= ST_BAD_BIN;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        hist_addr_reg <= HW'(b_reg);
                        center_reg    <= ctr_sat;
                        state_reg     <= S_RD_H;
                    end
                end
                S_RD_I:
                begin
                    state_reg <= S_LAT_I;
                end
                S_LAT_I:
                begin
                    ci_reg[0] <= rx_data;
                    ci_reg[1] <= ry_data;
                    ci_reg[2] <= rz_data;
                    state_reg <= S_RD_J;
                end
                S_RD_J:
                begin
                    state_reg <= S_LAT_J;
                end
                S_LAT_J:
                begin
                    cj_reg[0] <= rx_data;
                    cj_reg[1] <= ry_data;
                    cj_reg[2] <= rz_data;
                    sum_reg   <= '0;
                    axis_reg  <= '0;
                    state_reg <= S_AX_PREP;
                end
                S_AX_PREP:
                begin
                    m_reg     <= mag;
                    mw_reg    <= mag;
                    len_reg   <= axis_len;
                    state_reg <= (axis_len != '0) ? S_AX_GO : S_SQ;
                end
                S_AX_GO:
                begin
                    state_reg <= S_AX_WAIT;
                end
                S_AX_WAIT:
                begin
                    if (div_done)
                    begin
                        mw_reg    <= ({div_rem, 1'b0} >= {1'b0, len_reg})
                                     ? len_reg - div_rem : div_rem;
                        state_reg <= S_SQ;
                    end
                end
                S_SQ:
                begin
                    prod_reg  <= 64'(mw_reg) * 64'(mw_reg);
                    state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    sum_reg <= sum_wide[64] ? '1 : sum_wide[63:0];
                    if (axis_reg == 2'd2)
                    begin
                        state_reg <= S_SQRT_GO;
                    end
                    else
                    begin
                        axis_reg  <= axis_reg + 2'd1;
                        state_reg <= S_AX_PREP;
                    end
                end
                S_SQRT_GO:
                begin
                    state_reg <= S_SQRT_WAIT;
                end
                S_SQRT_WAIT:
                begin
                    if (sqrt_done)
                    begin
                        r_reg     <= sqrt_root;
                        state_reg <= (sqrt_root >= cutoff_reg) ? S_NEXT : S_BIN_GO;
                    end
                end
                S_BIN_GO:
                begin
                    state_reg <= S_BIN_WAIT;
                end
                S_BIN_WAIT:
                begin
                    if (div_done)
                    begin
                        hist_addr_reg <= HW'(div_quot);
                        state_reg     <= (div_quot < 32'(nb_reg)) ? S_HRD : S_NEXT;
                    end
                end
                S_HRD:
                begin
                    state_reg <= S_HWR;
                end
                S_HWR:
                begin
                    state_reg <= S_NEXT;
                end
                S_NEXT:
                begin
                    if (32'(j_reg) + 32'd1 < 32'(n_reg))
                    begin
                        j_reg     <= j_reg + CW'(1);
                        state_reg <= S_RD_J;
                    end
                    else if (32'(i_reg) + 32'd2 < 32'(n_reg))
                    begin
                        i_reg     <= i_reg + CW'(1);
                        j_reg     <= i_reg + CW'(2);
                        state_reg <= S_RD_I;
                    end
                    else
                    begin
                        state_reg <= S_ACC_END;
                    end
                end
                S_ACC_END:
                begin
                    snap_reg      <= snap_inc;
                    done_reg      <= 1'b1;
                    status_reg    <= ST_OK;
                    center_reg    <= '0;
                    count_out_reg <= '0;
                    g_reg         <= '0;
                    state_reg     <= S_IDLE;
                end
                S_RD_H:
                begin
                    state_reg <= S_RD_D;
                end
                S_RD_D:
                begin
                    cnt_reg       <= hist_rdata;
                    count_out_reg <= hist_rdata;
                    g_step_reg    <= G_VOL;
                    if (hist_rdata == '0)
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= ST_OK;
                        g_reg      <= '0;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_G_GO;
                    end
                end
                S_G_GO:
                begin
                    state_reg <= S_G_WAIT;
                end
                S_G_WAIT:
                begin
                    if (bn_done)
                    begin
                        if (g_step_reg == G_DIV)
                        begin
                            done_reg   <= 1'b1;
                            status_reg <= ST_OK;
                            g_reg      <= bn_quot;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            g_step_reg <= g_step_reg + 4'd1;
                            state_reg  <= S_G_GO;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    rdf_ram #(.WIDTH(32), .DEPTH(MAX_ATOMS)) u_coord_x (
        .clk   (clk),
        .we    (load_we),
        .waddr (AW'(atom_index)),
        .wdata (pos_x),
        .raddr (coord_raddr),
        .rdata (rx_data)
    );

    rdf_ram #(.WIDTH(32), .DEPTH(MAX_ATOMS)) u_coord_y (
        .clk   (clk),
        .we    (load_we),
        .waddr (AW'(atom_index)),
        .wdata (pos_y),
        .raddr (coord_raddr),
        .rdata (ry_data)
    );

    rdf_ram #(.WIDTH(32), .DEPTH(MAX_ATOMS)) u_coord_z (
        .clk   (clk),
        .we    (load_we),
        .waddr (AW'(atom_index)),
        .wdata (pos_z),
        .raddr (coord_raddr),
        .rdata (rz_data)
    );

    rdf_ram #(.WIDTH(32), .DEPTH(MAX_BINS)) u_hist (
        .clk   (clk),
        .we    (hist_we),
        .waddr (hist_addr_reg),
        .wdata (hist_wdata),
        .raddr (hist_addr_reg),
        .rdata (hist_rdata)
    );

    rdf_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    rdf_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == S_SQRT_GO),
        .radicand (sum_reg),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    rdf_bignum #(.SHIFT(SH)) u_bignum (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (bn_req),
        .done     (bn_done),
        .quotient (bn_quot)
    );

    assign done         = done_reg;
    assign status       = status_reg;
    assign bin_center   = center_reg;
    assign bin_count    = count_out_reg;
    assign g_value      = g_reg;
    assign sample_total = snap_reg;

endmodule

[tb/rdf_checker.sv]
`timescale 1ns / 1ps

module rdf_checker import rdf_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  command,
    input  logic [9:0]  atom_index,
    input  logic [31:0] pos_x,
    input  logic [31:0] pos_y,
    input  logic [31:0] pos_z,
    input  logic [10:0] atom_count,
    input  logic [9:0]  bin_index,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    input  logic        done,
    input  logic [1:0]  status,
    input  logic [31:0] bin_center,
    input  logic [31:0] bin_count,
    input  logic [31:0] g_value,
    input  logic [31:0] sample_total,
    output int          errors,
    output int          pending
);

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] center;
        logic [31:0] count;
        logic [31:0] g;
        logic [31:0] total;
    } rdf_result_t;

    localparam int NUM_SLOTS = 1024;
    localparam int NUM_BINS  = 1024;

    logic [31:0] atom_x [NUM_SLOTS];
    logic [31:0] atom_y [NUM_SLOTS];
    logic [31:0] atom_z [NUM_SLOTS];
    logic [31:0] hist [NUM_BINS];
    logic [31:0] snapshots;
    logic [31:0] r_cut, dr, len_x, len_y, len_z;
    logic [47:0] volume;

    rdf_result_t result_fifo [$];

    assign pending = result_fifo.size();

    function automatic logic [63:0] wrapped_sq(logic [31:0] a, logic [31:0] b, logic [31:0] len);
        logic signed [33:0] d;
        logic [63:0] m, q, ql, span;
        d = $signed({{2{b[31]}}, b}) - $signed({{2{a[31]}}, a});
        m = (d < 0) ? 64'(-d) : 64'(d);
        if (len != 0)
        begin
            span = 64'(len);
            q = (2 * m + span) / (2 * span);
            ql = q * span;
            m = (ql > m) ? ql - m : m - ql;
        end
        return m * m;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] s);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > s)
            b = b >> 2;
        while (b != 0)
        begin
            if (s >= res + b)
            begin
                s = s - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [31:0] bin_total();
        logic [31:0] n;
        if (dr == 0)
            return 0;
        n = r_cut / dr;
        return (n > NUM_BINS) ? NUM_BINS : n;
    endfunction

    function automatic logic [31:0] g_of(logic [31:0] cnt, logic [31:0] idx, logic [63:0] n);
        logic [319:0] num, den;
        logic [63:0]  i;
        if (cnt == 0)
            return 0;
        i = 64'(idx);
        num = 320'(cnt);
        num = num * volume;
        num = num * 3;
        num = num << (3 * 16 + 28);
        den = 320'(PI_Q29);
        den = den * snapshots;
        den = den * (n * (n - 1));
        den = den * dr;
        den = den * dr;
        den = den * dr;
        den = den * (3 * i * i + 3 * i + 1);
        if (num >= (den << 32))
            return 32'hFFFF_FFFF;
        return 32'(num / den);
    endfunction

    task automatic predict_command(output rdf_result_t r);
        logic [31:0] n, nb, bn;
        logic [64:0] acc;
        logic [63:0] sep, c;
        r = '0;
        case (command)
            CMD_LOAD:
            begin
                atom_x[atom_index] = pos_x;
                atom_y[atom_index] = pos_y;
                atom_z[atom_index] = pos_z;
            end
            CMD_ACCUM:
            begin
                n = (atom_count > NUM_SLOTS) ? NUM_SLOTS : 32'(atom_count);
                if (n < 2)
                    r.status = ST_FEW_ATOM;
                else
                begin
                    nb = bin_total();
                    if (nb != 0)
                    begin
                        for (int i = 0; i < n; i++)
                        begin
                            for (int j = i + 1; j < n; j++)
                            begin
                                acc = 65'(wrapped_sq(atom_x[i], atom_x[j], len_x))
                                    + 65'(wrapped_sq(atom_y[i], atom_y[j], len_y));
                                if (acc[64])
                                    acc = 65'h0_FFFF_FFFF_FFFF_FFFF;
                                acc = acc + 65'(wrapped_sq(atom_z[i], atom_z[j], len_z));
                                if (acc[64])
                                    acc = 65'h0_FFFF_FFFF_FFFF_FFFF;
                                sep = int_sqrt(acc[63:0]);
                                if (sep < 64'(r_cut))
                                begin
                                    c = sep / dr;
                                    if (c < 64'(nb) && hist[c] != 32'hFFFF_FFFF)
                                        hist[c] = hist[c] + 1;
                                end
                            end
                        end
                    end
                    if (snapshots != 32'hFFFF_FFFF)
                        snapshots = snapshots + 1;
                end
            end
            CMD_READ:
            begin
                nb = bin_total();
                bn = 32'(bin_index);
                if (snapshots == 0)
                    r.status = ST_NO_SAMP;
                else if (atom_count < 2)
                    r.status = ST_FEW_ATOM;
                else if (volume == 0 || nb < MIN_BINS || bn >= nb)
                    r.status = ST_BAD_BIN;
                else
                begin
                    c = ((64'd2 * bn + 1) * dr + 1) >> 1;
                    r.center = (c > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : c[31:0];
                    r.count = hist[bn];
                    r.g = g_of(hist[bn], bn, 64'(atom_count));
                end
            end
            default:
            begin
                foreach (hist[k])
                    hist[k] = 0;
                snapshots = 0;
            end
        endcase
        r.total = snapshots;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rdf_result_t want, got;
        if (!rst_n)
        begin
            foreach (hist[k])
                hist[k] = 0;
            snapshots = 0;
            r_cut = 655360;
            dr = 6554;
            len_x = 1310720;
            len_y = 1310720;
            len_z = 1310720;
            volume = 524288000;
            result_fifo.delete();
            errors = 0;
        end
        else
        begin
            if (done)
            begin
                got = '{status, bin_center, bin_count, g_value, sample_total};
                if (result_fifo.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result %h", $time, got);
                end
                else
                begin
                    want = result_fifo.pop_front();
                    if (got.status != want.status)
                    begin
                        errors++;
                        $display("%0t: status expected %0d actual %0d", $time, want.status,
                                 got.status);
                    end
                    if (got.center != want.center)
                    begin
                        errors++;
                        $display("%0t: bin_center expected %h actual %h", $time, want.center,
                                 got.center);
                    end
                    if (got.count != want.count)
                    begin
                        errors++;
                        $display("%0t: bin_count expected %0d actual %0d", $time, want.count,
                                 got.count);
                    end
                    if (got.g != want.g)
                    begin
                        errors++;
                        $display("%0t: g_value expected %h actual %h", $time, want.g, got.g);
                    end
                    if (got.total != want.total)
                    begin
                        errors++;
                        $display("%0t: sample_total expected %0d actual %0d", $time,
                                 want.total, got.total);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CUTOFF: r_cut = cfg_data[31:0];
                    REG_BIN_W:  dr = cfg_data[31:0];
                    REG_BOX_X:  len_x = cfg_data[31:0];
                    REG_BOX_Y:  len_y = cfg_data[31:0];
                    REG_BOX_Z:  len_z = cfg_data[31:0];
                    REG_VOLUME: volume = cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy)
            begin
                predict_command(want);
                result_fifo.push_back(want);
            end
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;
    import rdf_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  command;
    logic [9:0]  atom_index;
    logic [31:0] pos_x, pos_y, pos_z;
    logic [10:0] atom_count;
    logic [9:0]  bin_index;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [47:0] cfg_data;
    logic        done;
    logic [1:0]  status;
    logic [31:0] bin_center, bin_count, g_value, sample_total;
    int          errors;
    int          pending;

    logic [47:0] phase_cfg [6][6];
    logic [31:0] phase_span [6];
    logic        written [1024];
    bit          quiet;

    pair_distance_histogram_rdf u_top (.*);

    rdf_checker u_checker (.*);

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    initial
    begin
        #120_000_000;
        $display("Some tests failed");
        $finish;
    end

    function automatic logic [31:0] rand_coord(logic [31:0] span);
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic int loaded_prefix();
        int p;
        p = 0;
        while (p < 1024 && written[p])
            p++;
        return p;
    endfunction

    task automatic send(logic [1:0] cmd, logic [9:0] idx, logic [31:0] x, logic [31:0] y,
                        logic [31:0] z, logic [10:0] n, logic [9:0] b);
        int gap, r;
        gap = 0;
        if (!quiet)
        begin
            r = $urandom_range(0, 99);
            if (r >= 95)
                gap = $urandom_range(10, 60);
            else if (r >= 65)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        atom_index <= idx;
        pos_x <= x;
        pos_y <= y;
        pos_z <= z;
        atom_count <= n;
        bin_index <= b;
        if (cmd == CMD_LOAD)
            written[idx] = 1'b1;
        #1;
        while (busy)
        begin
            @(negedge clk);
            #1;
        end
        @(negedge clk);
    endtask

    task automatic settle();
        start <= 1'b0;
        @(negedge clk);
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (20) @(negedge clk);
    endtask

    initial
    begin
        int p, r, n, hi;
        logic [31:0] sp;
        rst_n = 1'b0;
        start = 1'b0;
        command = CMD_LOAD;
        atom_index = '0;
        pos_x = '0;
        pos_y = '0;
        pos_z = '0;
        atom_count = '0;
        bin_index = '0;
        cfg_we = 1'b0;
        cfg_index = REG_CUTOFF;
        cfg_data = '0;
        foreach (written[k])
            written[k] = 1'b0;
        phase_cfg[0] = '{655360, 6554, 1310720, 1310720, 1310720, 524288000};
        phase_cfg[1] = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 48'hFFFF_FFFF_FFFF};
        phase_cfg[2] = '{64 << 16, 1 << 12, 32 << 16, 16 << 16, 0, 1};
        phase_cfg[3] = '{1, 0, 1, 1, 1, 0};
        phase_cfg[4] = '{3 << 16, 1 << 15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                         1000 << 16};
        phase_cfg[5] = '{12 << 16, 3 << 14, 10 << 16, 10 << 16, 10 << 16, 1000 << 16};
        phase_span = '{1310720, 1 << 30, 20 << 16, 1 << 16, 2 << 16, 10 << 16};

        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        while (busy)
            @(negedge clk);

        for (int ph = 0; ph < 6; ph++)
        begin
            if (ph > 0)
                settle();
            for (int k = 0; k < 6; k++)
            begin
                cfg_we <= 1'b1;
                cfg_index <= 3'(k);
                cfg_data <= (k == REG_VOLUME) ? phase_cfg[ph][k]
                            : {16'($urandom), phase_cfg[ph][k][31:0]};
                @(negedge clk);
            end
            cfg_we <= 1'b0;
            @(negedge clk);
            quiet = (ph % 3 == 1);
            sp = phase_span[ph];

            if (ph == 0)
            begin
                send(CMD_READ, 10'h3FF, '1, '1, '1, 11'd5, 10'd0);
                send(CMD_ACCUM, 0, 0, 0, 0, 11'd0, 0);
                send(CMD_ACCUM, 0, 0, 0, 0, 11'd1, 0);
                send(CMD_LOAD, 10'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 0, 0);
                send(CMD_LOAD, 10'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0);
                send(CMD_LOAD, 10'd2, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 0, 0);
                send(CMD_LOAD, 10'd3, 32'h0001_8000, 32'h0002_4000, 32'h0003_2000, 0, 0);
                send(CMD_LOAD, 10'd1023, 32'h0, 32'h0, 32'h0, 11'h7FF, 10'h3FF);
                send(CMD_ACCUM, 0, 0, 0, 0, 11'd4, 0);
                send(CMD_READ, 0, 0, 0, 0, 11'd1, 10'd0);
                send(CMD_READ, 0, 0, 0, 0, 11'd4, 10'd0);
                send(CMD_READ, 0, 0, 0, 0, 11'd4, 10'd6);
                send(CMD_READ, 0, 0, 0, 0, 11'h7FF, 10'd6);
                send(CMD_READ, 0, 0, 0, 0, 11'd1024, 10'd99);
                send(CMD_READ, 0, 0, 0, 0, 11'd4, 10'd100);
                send(CMD_READ, 0, 0, 0, 0, 11'd4, 10'h3FF);
                send(CMD_CLEAR, '1, '1, '1, '1, '1, '1);
                send(CMD_READ, 0, 0, 0, 0, 11'd4, 10'd6);
                send(CMD_ACCUM, 0, 0, 0, 0, 11'd3, 0);
                send(CMD_READ, 0, 0, 0, 0, 11'd3, 10'd0);
            end

            for (int it = 0; it < 245; it++)
            begin
                p = loaded_prefix();
                r = $urandom_range(0, 99);
                if (r < 50)
                begin
                    if ($urandom_range(0, 1) == 0)
                        hi = (p < 24) ? p : 30;
                    else
                        hi = 1023;
                    send(CMD_LOAD, 10'($urandom_range(0, hi)), rand_coord(sp), rand_coord(sp),
                         rand_coord(sp), 11'($urandom), 10'($urandom));
                end
                else if (r < 65)
                begin
                    r = $urandom_range(0, 199);
                    if (r < 10)
                        n = $urandom_range(0, 1);
                    else if (r < 198 || p < 8)
                        n = $urandom_range(2, (p < 6) ? p : 6);
                    else
                        n = $urandom_range(7, (p < 20) ? p : 20);
                    send(CMD_ACCUM, 10'($urandom), $urandom, $urandom, $urandom, 11'(n),
                         10'($urandom));
                end
                else if (r < 97)
                begin
                    r = $urandom_range(0, 9);
                    if (r == 0)
                        n = $urandom_range(0, 1);
                    else if (r == 1)
                        n = $urandom_range(0, 2047);
                    else
                        n = $urandom_range(2, 1024);
                    send(CMD_READ, 10'($urandom), $urandom, $urandom, $urandom, 11'(n),
                         ($urandom_range(0, 9) < 6) ? 10'($urandom_range(0, 20))
                                                    : 10'($urandom));
                end
                else
                    send(CMD_CLEAR, 10'($urandom), $urandom, $urandom, $urandom,
                         11'($urandom), 10'($urandom));
            end
        end

        settle();
        repeat (50) @(negedge clk);
        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
